[hw/rtl/lpd_pkg.sv]
package lpd_pkg;

  localparam int PACKET_BYTES       = 36;
  localparam int SAMPLES_PER_PACKET = 8;
  localparam int FILL_W             = $clog2(PACKET_BYTES + 1);
  localparam int SIDX_W             = $clog2(SAMPLES_PER_PACKET);

  // byte positions inside a full window
  localparam int SPEED_POS  = 4;
  localparam int START_POS  = 6;
  localparam int SAMPLE_POS = 8;
  localparam int END_POS    = 32;
  localparam int TAIL_POS   = 34;

  // checksum: 17 words folded into 32 bits, then into 15 bits
  localparam int CHK_WORDS  = 17;
  localparam int CHK_GROUP  = 3;
  localparam int CHK_GROUPS = (CHK_WORDS + CHK_GROUP - 1) / CHK_GROUP;
  localparam int CHK_W      = 15;

  localparam int FULL_TURN_RAW = 23040;
  localparam int MIN_SPAN_RAW  = 7;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [7:0]  SYNC0_RST     = 8'h55;
  localparam logic [7:0]  SYNC1_RST     = 8'hAA;
  localparam logic [7:0]  SYNC2_RST     = 8'h03;
  localparam logic [7:0]  SYNC3_RST     = 8'h08;
  localparam logic [15:0] ANGLE_MIN_RST = 16'd40960;
  localparam logic [15:0] ANGLE_MAX_RST = 16'd64000;
  localparam logic [14:0] SPAN_MAX_RST  = 15'd1280;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;

  typedef enum logic [2:0] {
    REG_SYNC0     = 3'd0,
    REG_SYNC1     = 3'd1,
    REG_SYNC2     = 3'd2,
    REG_SYNC3     = 3'd3,
    REG_ANGLE_MIN = 3'd4,
    REG_ANGLE_MAX = 3'd5,
    REG_SPAN_MAX  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [3:0][7:0] sync;
    word_t           angle_min;
    word_t           angle_max;
    logic [14:0]     span_max;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLES_PER_PACKET-1:0][2:0][7:0] smp;
    word_t                                   start_angle;
    word_t                                   end_angle;
    word_t                                   speed;
    logic [CHK_W-1:0]                        chk;
  } pkt_t;

  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } push_t;

endpackage

[hw/rtl/lpd_if.sv]
interface lpd_in_if;
  logic          valid;
  logic          ready;
  lpd_pkg::byte_t rx_byte;
  logic          flush;

  modport source (output valid, output rx_byte, output flush, input ready);
  modport sink   (input valid, input rx_byte, input flush, output ready);
endinterface

interface lpd_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] distance;
  logic [7:0]  quality;
  logic [2:0]  sample_index;
  logic [15:0] start_angle_raw;
  logic [15:0] end_angle_raw;
  logic [15:0] rot_speed;
  logic [14:0] checksum_word;
  logic        last;

  modport source (
    output valid, output distance, output quality, output sample_index,
    output start_angle_raw, output end_angle_raw, output rot_speed,
    output checksum_word, output last, input ready
  );
  modport sink (
    input valid, input distance, input quality, input sample_index,
    input start_angle_raw, input end_angle_raw, input rot_speed,
    input checksum_word, input last, output ready
  );
endinterface

[hw/rtl/lpd_cfg.sv]
module lpd_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lpd_pkg::APB_AW-1:0] paddr,
  input  logic [lpd_pkg::APB_DW-1:0] pwdata,
  output logic [lpd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output lpd_pkg::cfg_t              cfg
);
  import lpd_pkg::*;

  cfg_t     regs;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sync      <= {SYNC3_RST, SYNC2_RST, SYNC1_RST, SYNC0_RST};
      regs.angle_min <= ANGLE_MIN_RST;
      regs.angle_max <= ANGLE_MAX_RST;
      regs.span_max  <= SPAN_MAX_RST;
    end else if (wr) begin
      case (idx)
        REG_SYNC0:     regs.sync[0]   <= pwdata[7:0];
        REG_SYNC1:     regs.sync[1]   <= pwdata[7:0];
        REG_SYNC2:     regs.sync[2]   <= pwdata[7:0];
        REG_SYNC3:     regs.sync[3]   <= pwdata[7:0];
        REG_ANGLE_MIN: regs.angle_min <= pwdata[15:0];
        REG_ANGLE_MAX: regs.angle_max <= pwdata[15:0];
        REG_SPAN_MAX:  regs.span_max  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SYNC0:     prdata = {24'b0, regs.sync[0]};
      REG_SYNC1:     prdata = {24'b0, regs.sync[1]};
      REG_SYNC2:     prdata = {24'b0, regs.sync[2]};
      REG_SYNC3:     prdata = {24'b0, regs.sync[3]};
      REG_ANGLE_MIN: prdata = {16'b0, regs.angle_min};
      REG_ANGLE_MAX: prdata = {16'b0, regs.angle_max};
      REG_SPAN_MAX:  prdata = {17'b0, regs.span_max};
      default:       prdata = '0;
    endcase
  end

endmodule

[hw/rtl/lpd_front.sv]
module lpd_front (
  input  logic           clk,
  input  logic           rst,
  lpd_in_if.sink         in_ch,
  input  logic           q_space,
  input  lpd_pkg::cfg_t  cfg,
  output lpd_pkg::push_t push
);
  import lpd_pkg::*;

  byte_t win [PACKET_BYTES];

  logic              accept;
  logic [FILL_W-1:0] fill, fill_base, fill_next;
  logic [2:0]        since_good;
  logic              good;

  // per-cycle markers: byte taken, and full window to check
  logic chk0, m0, m1, m2;
  logic v1, v2, v3;

  // stage 1
  logic [31:0] s1_part [CHK_GROUPS];
  logic        s1_hdr_ok;
  logic [16:0] s1_diff;
  word_t       s1_tail;
  pkt_t        s1_pkt;

  // stage 2
  logic [31:0] s2_acc_a, s2_acc_b;
  logic [17:0] s2_span;
  logic        s2_hdr_ok;
  word_t       s2_tail;
  pkt_t        s2_pkt;

  // stage 3
  logic [31:0] s3_acc;
  logic        s3_span_ok;
  logic        s3_hdr_ok;
  word_t       s3_tail;
  pkt_t        s3_pkt;

  logic [CHK_W-1:0] fold;
  logic [31:0]      part [CHK_GROUPS];
  pkt_t             snap;
  word_t            sa, ea;
  logic             sync_ok, angle_ok;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = q_space;

  // window shifts on every byte; oldest at index 0
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < PACKET_BYTES - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[PACKET_BYTES-1] <= in_ch.rx_byte;
    end
  end

  // bytes since the last clear, saturating at a full window
  always_comb begin
    if (!accept) begin
      fill_base = fill;
    end else if (in_ch.flush) begin
      fill_base = FILL_W'(1);
    end else if (fill == FILL_W'(PACKET_BYTES)) begin
      fill_base = fill;
    end else begin
      fill_base = fill + 1'b1;
    end
    since_good = {2'b0, m0} + {2'b0, m1} + {2'b0, m2} + {2'b0, accept};
    if (good && FILL_W'(since_good) < fill_base) begin
      fill_next = FILL_W'(since_good);
    end else begin
      fill_next = fill_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      chk0 <= 1'b0;
      m0   <= 1'b0;
      m1   <= 1'b0;
      m2   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
    end else begin
      fill <= fill_next;
      chk0 <= accept && (fill_next == FILL_W'(PACKET_BYTES));
      m0   <= accept;
      m1   <= m0;
      m2   <= m1;
      // a good packet clears the window, so younger checks die
      v1   <= chk0 && !good;
      v2   <= v1 && !good;
      v3   <= v2 && !good;
    end
  end

  // stage 1 inputs: partial sums of shifted words, header tests, payload
  always_comb begin
    logic [31:0] term;
    int          k;
    term = '0;
    for (int j = 0; j < CHK_GROUPS; j++) begin
      part[j] = '0;
      for (int m = 0; m < CHK_GROUP; m++) begin
        k = j * CHK_GROUP + m;
        if (k < CHK_WORDS) begin
          term    = {16'b0, win[2*k+1], win[2*k]} << (CHK_WORDS - 1 - k);
          part[j] = part[j] + term;
        end
      end
    end
    for (int i = 0; i < SAMPLES_PER_PACKET; i++) begin
      for (int b = 0; b < 3; b++) begin
        snap.smp[i][b] = win[SAMPLE_POS + 3*i + b];
      end
    end
    sa               = {win[START_POS+1], win[START_POS]};
    ea               = {win[END_POS+1], win[END_POS]};
    snap.start_angle = sa;
    snap.end_angle   = ea;
    snap.speed       = {win[SPEED_POS+1], win[SPEED_POS]};
    snap.chk         = {win[TAIL_POS+1][6:0], win[TAIL_POS]};
    sync_ok  = win[0] == cfg.sync[0] && win[1] == cfg.sync[1] &&
               win[2] == cfg.sync[2] && win[3] == cfg.sync[3];
    angle_ok = sa >= cfg.angle_min && sa <= cfg.angle_max &&
               ea >= cfg.angle_min && ea <= cfg.angle_max;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < CHK_GROUPS; j++) begin
      s1_part[j] <= part[j];
    end
    s1_hdr_ok <= sync_ok && angle_ok;
    s1_diff   <= {1'b0, ea} - {1'b0, sa};
    s1_tail   <= {win[TAIL_POS+1], win[TAIL_POS]};
    s1_pkt    <= snap;
  end

  // stage 2: two sums of three partials, wrapped span
  always_ff @(posedge clk) begin
    s2_acc_a  <= s1_part[0] + s1_part[1] + s1_part[2];
    s2_acc_b  <= s1_part[3] + s1_part[4] + s1_part[5];
    s2_span   <= {s1_diff[16], s1_diff} +
                 (s1_diff[16] ? 18'(FULL_TURN_RAW) : 18'd0);
    s2_hdr_ok <= s1_hdr_ok;
    s2_tail   <= s1_tail;
    s2_pkt    <= s1_pkt;
  end

  // stage 3: full accumulator, span limits
  always_ff @(posedge clk) begin
    s3_acc     <= s2_acc_a + s2_acc_b;
    s3_span_ok <= !s2_span[17] &&
                  s2_span[16:0] >= 17'(MIN_SPAN_RAW) &&
                  s2_span[16:0] <= {2'b0, cfg.span_max};
    s3_hdr_ok  <= s2_hdr_ok;
    s3_tail    <= s2_tail;
    s3_pkt     <= s2_pkt;
  end

  // 15-bit fold; tail bit 15 set never matches
  assign fold = s3_acc[CHK_W-1:0] + s3_acc[2*CHK_W-1:CHK_W];
  assign good = v3 && s3_hdr_ok && s3_span_ok && (s3_tail == {1'b0, fold});

  assign push.valid = good;
  assign push.pkt   = s3_pkt;

endmodule

[hw/rtl/lpd_back.sv]
module lpd_back (
  input  logic           clk,
  input  logic           rst,
  input  lpd_pkg::push_t push,
  output logic           q_space,
  lpd_out_if.source      out_ch
);
  import lpd_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  pkt_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [SIDX_W-1:0] sidx;
  logic              load, pop;
  pkt_t              head;
  byte_t             lo, hi;

  logic        out_valid;
  logic [13:0] out_range;
  logic [7:0]  out_quality;
  logic [2:0]  out_index;
  word_t       out_start, out_end, out_speed;
  logic [14:0] out_chk;
  logic        out_last;

  assign q_space = count != QCNT_W'(QDEPTH);
  assign head    = q[rd_ptr];
  assign load    = (count != '0) && (!out_valid || out_ch.ready);
  assign pop     = load && (sidx == SIDX_W'(SAMPLES_PER_PACKET - 1));
  assign lo      = head.smp[sidx][0];
  assign hi      = head.smp[sidx][1];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q[wr_ptr] <= push.pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      sidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push.valid) - QCNT_W'(pop);
      if (load) begin
        sidx <= pop ? '0 : sidx + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // flagged samples read as zero range
  always_ff @(posedge clk) begin
    if (load) begin
      out_range   <= hi[7] ? 14'd0 : {hi[5:0], lo};
      out_quality <= head.smp[sidx][2];
      out_index   <= 3'(sidx);
      out_start   <= head.start_angle;
      out_end     <= head.end_angle;
      out_speed   <= head.speed;
      out_chk     <= head.chk;
      out_last    <= pop;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.distance        = out_range;
  assign out_ch.quality         = out_quality;
  assign out_ch.sample_index    = out_index;
  assign out_ch.start_angle_raw = out_start;
  assign out_ch.end_angle_raw   = out_end;
  assign out_ch.rot_speed       = out_speed;
  assign out_ch.checksum_word   = out_chk;
  assign out_ch.last            = out_last;

endmodule

[hw/rtl/lidar_packet_deframer_unit.sv]
// lidar serial packet deframer: takes one received byte per transaction on
// in_ch into a 36-byte sliding window and, for every byte that leaves the
// window full, checks the sync bytes, the 15-bit folded checksum of the 17
// leading little-endian words against the tail word, the start and end angle
// limits and the wrapped angular span. a good packet empties the window and
// yields eight sample transactions on out_ch (range, quality, index, packet
// angles, speed, checksum, last on the eighth); a bad window drops its oldest
// byte. flush empties the window before its byte. the block takes one byte
// every cycle; the window feeds the pipelined check, a good packet goes into
// the packet queue, and its samples then leave the output register at one per
// cycle while out_ch is ready. input stalls only while the two-entry packet
// queue in front of the output register is full.
module lidar_packet_deframer_unit (
  input  logic                       clk,
  input  logic                       rst,
  lpd_in_if.sink                     in_ch,
  lpd_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lpd_pkg::APB_AW-1:0] paddr,
  input  logic [lpd_pkg::APB_DW-1:0] pwdata,
  output logic [lpd_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import lpd_pkg::*;

  cfg_t  cfg;      // live register values
  push_t push;     // good packet from the check pipeline
  logic  q_space;  // queue can take one more packet

  // register block; the user must write it only while idle, the block itself does not enforce it
  lpd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // window, fill tracking and pipelined packet check
  lpd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_space (q_space),
    .cfg     (cfg),
    .push    (push)
  );

  // packet queue and sample output register
  lpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .q_space (q_space),
    .out_ch  (out_ch)
  );

endmodule
